FILE: rtl/core/wsp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsp_pkg
// Shared types and constants of the WAV stream parser: parse phase codes,
// chunk tags, result kinds, error codes and the beat layouts.
// ----------------------------------------------------------------------------
package wsp_pkg;

   // Field widths.
   localparam int BYTE_W   = 8;
   localparam int WORD_W   = 32;
   localparam int HALF_W   = 16;
   localparam int KIND_W   = 2;
   localparam int ERR_W    = 3;
   localparam int PHASE_W  = 4;
   localparam int INDEX_W  = 4;
   localparam int POS_W    = 2;
   localparam int GAIN_W   = 16;
   localparam int RSP_DATA_W = 88;

   // Result layout in the response data word, lowest bit up.
   localparam int RSP_ERR_LSB   = 0;
   localparam int RSP_RATE_LSB  = RSP_ERR_LSB + ERR_W;
   localparam int RSP_CH_LSB    = RSP_RATE_LSB + WORD_W;
   localparam int RSP_LEFT_LSB  = RSP_CH_LSB + HALF_W;
   localparam int RSP_RIGHT_LSB = RSP_LEFT_LSB + HALF_W;
   localparam int RSP_USED_W    = RSP_RIGHT_LSB + HALF_W;

   // Unity gain in Q4.12.
   localparam logic [GAIN_W-1:0] GAIN_UNITY = 16'd4096;

   // Parse phases.
   localparam logic [PHASE_W-1:0] PH_RIFF      = 4'd0;
   localparam logic [PHASE_W-1:0] PH_RSIZE     = 4'd1;
   localparam logic [PHASE_W-1:0] PH_WAVE      = 4'd2;
   localparam logic [PHASE_W-1:0] PH_CID       = 4'd3;
   localparam logic [PHASE_W-1:0] PH_FMTSIZE   = 4'd4;
   localparam logic [PHASE_W-1:0] PH_DATASIZE  = 4'd5;
   localparam logic [PHASE_W-1:0] PH_OTHERSIZE = 4'd6;
   localparam logic [PHASE_W-1:0] PH_FMTBODY   = 4'd7;
   localparam logic [PHASE_W-1:0] PH_SKIP      = 4'd8;
   localparam logic [PHASE_W-1:0] PH_DATA      = 4'd9;
   localparam logic [PHASE_W-1:0] PH_IDLE      = 4'd10;

   // Chunk tags as little-endian words.
   localparam logic [WORD_W-1:0] TAG_RIFF = 32'h4646_4952;
   localparam logic [WORD_W-1:0] TAG_WAVE = 32'h4556_4157;
   localparam logic [WORD_W-1:0] TAG_FMT  = 32'h2074_6D66;
   localparam logic [WORD_W-1:0] TAG_DATA = 32'h6174_6164;

   // Format checks.
   localparam logic [WORD_W-1:0] FMT_MIN_LEN = 32'd16;
   localparam logic [HALF_W-1:0] FMT_PCM     = 16'd1;
   localparam logic [HALF_W-1:0] BITS_16     = 16'd16;
   localparam logic [HALF_W-1:0] CH_MONO     = 16'd1;
   localparam logic [HALF_W-1:0] CH_STEREO   = 16'd2;
   localparam logic [INDEX_W-1:0] FMT_BODY_LAST = 4'd15;

   // Result kinds.
   localparam logic [KIND_W-1:0] KIND_AUDIO  = 2'd0;
   localparam logic [KIND_W-1:0] KIND_ACCEPT = 2'd1;
   localparam logic [KIND_W-1:0] KIND_REJECT = 2'd2;

   // Error codes.
   localparam logic [ERR_W-1:0] ERR_NONE      = 3'd0;
   localparam logic [ERR_W-1:0] ERR_BAD_TAG   = 3'd1;
   localparam logic [ERR_W-1:0] ERR_FMT_SHORT = 3'd2;
   localparam logic [ERR_W-1:0] ERR_NOT_PCM   = 3'd3;
   localparam logic [ERR_W-1:0] ERR_NOT_16BIT = 3'd4;
   localparam logic [ERR_W-1:0] ERR_CHANNELS  = 3'd5;
   localparam logic [ERR_W-1:0] ERR_MISSING   = 3'd6;

   // Saturation limits of the scaled quotient.
   localparam int QUO_W = 21;
   localparam logic signed [QUO_W-1:0] QUO_MAX = 21'sd32767;
   localparam logic signed [QUO_W-1:0] QUO_MIN = -21'sd32768;
   localparam logic [HALF_W-1:0] SAMPLE_MAX = 16'h7FFF;
   localparam logic [HALF_W-1:0] SAMPLE_MIN = 16'h8000;

   // One input beat as held in the input register.
   typedef struct packed {
      logic [BYTE_W-1:0] byte_value;
      logic              start_of_file;
      logic              end_of_file;
   } in_beat_type;

endpackage

FILE: rtl/core/wav_stream_parser_with_gain.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wav_stream_parser_with_gain
// Parses a RIFF/WAVE byte stream, reports header acceptance or rejection and
// turns the following 16-bit PCM samples into gain-scaled stereo frames.
// ----------------------------------------------------------------------------
// A result is registered twice: its byte beat is held in the input register,
// then parsed and scaled into the output register.
// Throughput: one byte per cycle while the output side does not stall, set
// by the single-pass parse and multiply.
// Reset is synchronous: the parser returns to the RIFF tag phase and the
// gain to unity (4096); no clearing pass is needed.
module wav_stream_parser_with_gain (
   input  logic         clock,
   input  logic         reset,
   input  logic         csr_we,
   input  logic [15:0]  csr_wdata,   // volume_gain
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [7:0]   req_tdata,   // byte_value
   input  logic [0:0]   req_tuser,   // start_of_file
   input  logic         req_tlast,   // end_of_file
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [87:0]  rsp_tdata,   // error_code, rate_hz, channel_count,
                                     // left_sample, right_sample, zero fill
   output logic [1:0]   rsp_tuser    // kind
);

   logic [wsp_pkg::GAIN_W-1:0] gain_ff;
   logic [wsp_pkg::GAIN_W-1:0] gain_in;
   logic                       take;
   logic                       beat_valid;
   wsp_pkg::in_beat_type       beat;

   // Volume register.
   assign gain_in = csr_we ? csr_wdata : gain_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         gain_ff <= wsp_pkg::GAIN_UNITY;
      end else begin
         gain_ff <= gain_in;
      end
   end

   wsp_in_reg u_in_reg (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .take       (take),
      .beat_valid (beat_valid),
      .beat       (beat)
   );

   wsp_parser u_parser (
      .clock      (clock),
      .reset      (reset),
      .beat_valid (beat_valid),
      .beat       (beat),
      .take       (take),
      .gain       (gain_ff),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

FILE: rtl/core/wsp_in_reg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsp_in_reg
// Input register: captures one byte beat and holds it until the parser
// takes it.
// ----------------------------------------------------------------------------
module wsp_in_reg (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [7:0]           req_tdata,   // byte_value
   input  logic [0:0]           req_tuser,   // start_of_file
   input  logic                 req_tlast,   // end_of_file
   input  logic                 take,
   output logic                 beat_valid,
   output wsp_pkg::in_beat_type beat
);

   logic                 valid_ff;
   logic                 valid_in;
   wsp_pkg::in_beat_type beat_ff;

   // The register is free when empty or when the parser takes it this cycle.
   assign req_tready = !valid_ff || take;
   assign valid_in   = req_tready ? req_tvalid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Payload carries no reset.
   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         beat_ff.byte_value    <= req_tdata;
         beat_ff.start_of_file <= req_tuser[0];
         beat_ff.end_of_file   <= req_tlast;
      end
   end

   assign beat_valid = valid_ff;
   assign beat       = beat_ff;

endmodule

FILE: rtl/core/wsp_gain_scale.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsp_gain_scale
// Scales one signed 16-bit sample by the unsigned Q4.12 gain, truncates
// toward zero and saturates to the int16 range.
// ----------------------------------------------------------------------------
module wsp_gain_scale (
   input  logic [wsp_pkg::HALF_W-1:0] raw_sample,
   input  logic [wsp_pkg::GAIN_W-1:0] gain,
   output logic [wsp_pkg::HALF_W-1:0] scaled_sample
);

   logic signed [32:0]               product;
   logic signed [32:0]               biased;
   logic signed [wsp_pkg::QUO_W-1:0] quotient;

   // Exact product of the signed sample and the zero-extended gain.
   assign product = $signed({{17{raw_sample[15]}}, raw_sample}) * $signed({17'b0, gain});

   // A negative product is biased so that the shift truncates toward zero.
   assign biased   = product[32] ? product + 33'sd4095 : product;
   assign quotient = $signed(biased[32:12]);

   // Clamp to the int16 range.
   always_comb begin
      if (quotient > wsp_pkg::QUO_MAX) begin
         scaled_sample = wsp_pkg::SAMPLE_MAX;
      end else if (quotient < wsp_pkg::QUO_MIN) begin
         scaled_sample = wsp_pkg::SAMPLE_MIN;
      end else begin
         scaled_sample = quotient[15:0];
      end
   end

endmodule

FILE: rtl/core/wsp_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsp_parser
// Header state machine and sample assembly. Each byte beat updates the
// parse state in one pass and may load one result into the output register.
// ----------------------------------------------------------------------------
module wsp_parser (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         beat_valid,
   input  wsp_pkg::in_beat_type         beat,
   output logic                         take,
   input  logic [wsp_pkg::GAIN_W-1:0]   gain,
   output logic                         rsp_tvalid,
   input  logic                         rsp_tready,
   output logic [wsp_pkg::RSP_DATA_W-1:0] rsp_tdata,
   output logic [wsp_pkg::KIND_W-1:0]   rsp_tuser
);

   // Parse state.
   logic [wsp_pkg::PHASE_W-1:0] phase_ff, phase_in, phase_c;
   logic [wsp_pkg::INDEX_W-1:0] idx_ff, idx_in, idx_c;
   logic [wsp_pkg::WORD_W-1:0]  acc_ff, acc_in, acc_c;
   logic [wsp_pkg::WORD_W-1:0]  len_ff, len_in, len_c;
   logic [wsp_pkg::HALF_W-1:0]  fmtc_ff, fmtc_in, fmtc_c;
   logic [wsp_pkg::HALF_W-1:0]  chan_ff, chan_in, chan_c;
   logic [wsp_pkg::WORD_W-1:0]  rate_ff, rate_in, rate_c;
   logic [wsp_pkg::HALF_W-1:0]  bits_ff, bits_in, bits_c;
   logic                        seen_ff, seen_in, seen_c;
   logic [wsp_pkg::BYTE_W-1:0]  lowb_ff, lowb_in, lowb_c;
   logic [wsp_pkg::HALF_W-1:0]  lefth_ff, lefth_in, lefth_c;
   logic [wsp_pkg::POS_W-1:0]   pos_ff, pos_in, pos_c;

   // Output register.
   logic                           rsp_valid_ff, rsp_valid_in;
   logic [wsp_pkg::KIND_W-1:0]     rsp_kind_ff;
   logic [wsp_pkg::RSP_DATA_W-1:0] rsp_data_ff;

   // Result of the current beat.
   logic                        res_valid;
   logic [wsp_pkg::KIND_W-1:0]  res_kind;
   logic [wsp_pkg::ERR_W-1:0]   res_err;
   logic [wsp_pkg::WORD_W-1:0]  res_rate;
   logic [wsp_pkg::HALF_W-1:0]  res_chan;
   logic [wsp_pkg::HALF_W-1:0]  res_left;
   logic [wsp_pkg::HALF_W-1:0]  res_right;
   logic [wsp_pkg::ERR_W-1:0]   err;

   logic [wsp_pkg::BYTE_W-1:0]  b;
   logic [wsp_pkg::WORD_W-1:0]  acc_field;
   logic                        field_done;
   logic [wsp_pkg::INDEX_W-1:0] idx_field;
   logic [wsp_pkg::WORD_W-1:0]  len_dec;
   logic [wsp_pkg::HALF_W-1:0]  scaled;

   assign b = beat.byte_value;

   // A beat is taken when the output register is free for its result.
   assign take = beat_valid && (!rsp_valid_ff || rsp_tready);

   // Start of file clears the state seen by this byte.
   always_comb begin
      if (beat.start_of_file) begin
         phase_c = wsp_pkg::PH_RIFF;
         idx_c   = '0;
         acc_c   = '0;
         len_c   = '0;
         fmtc_c  = '0;
         chan_c  = '0;
         rate_c  = '0;
         bits_c  = '0;
         seen_c  = 1'b0;
         lowb_c  = '0;
         lefth_c = '0;
         pos_c   = '0;
      end else begin
         phase_c = phase_ff;
         idx_c   = idx_ff;
         acc_c   = acc_ff;
         len_c   = len_ff;
         fmtc_c  = fmtc_ff;
         chan_c  = chan_ff;
         rate_c  = rate_ff;
         bits_c  = bits_ff;
         seen_c  = seen_ff;
         lowb_c  = lowb_ff;
         lefth_c = lefth_ff;
         pos_c   = pos_ff;
      end
   end

   // Four-byte little-endian field assembly.
   assign acc_field  = acc_c | ({24'b0, b} << {idx_c[1:0], 3'b000});
   assign field_done = (idx_c[1:0] == 2'd3);
   assign idx_field  = field_done ? '0 : idx_c + 4'd1;
   assign len_dec    = (len_c != '0) ? len_c - 32'd1 : len_c;

   wsp_gain_scale u_scale (
      .raw_sample    ({b, lowb_c}),
      .gain          (gain),
      .scaled_sample (scaled)
   );

   // Next state and result of one byte.
   always_comb begin
      phase_in  = phase_c;
      idx_in    = idx_c;
      acc_in    = acc_c;
      len_in    = len_c;
      fmtc_in   = fmtc_c;
      chan_in   = chan_c;
      rate_in   = rate_c;
      bits_in   = bits_c;
      seen_in   = seen_c;
      lowb_in   = lowb_c;
      lefth_in  = lefth_c;
      pos_in    = pos_c;
      res_valid = 1'b0;
      res_kind  = wsp_pkg::KIND_AUDIO;
      res_err   = wsp_pkg::ERR_NONE;
      res_rate  = '0;
      res_chan  = '0;
      res_left  = '0;
      res_right = '0;
      err       = wsp_pkg::ERR_NONE;

      case (phase_c)
         wsp_pkg::PH_RIFF, wsp_pkg::PH_WAVE: begin
            idx_in = idx_field;
            acc_in = acc_field;
            if (field_done) begin
               if (acc_field != ((phase_c == wsp_pkg::PH_RIFF) ?
                                 wsp_pkg::TAG_RIFF : wsp_pkg::TAG_WAVE)) begin
                  err = wsp_pkg::ERR_BAD_TAG;
               end else begin
                  phase_in = (phase_c == wsp_pkg::PH_RIFF) ?
                             wsp_pkg::PH_RSIZE : wsp_pkg::PH_CID;
                  acc_in   = '0;
               end
            end
         end
         wsp_pkg::PH_RSIZE: begin
            idx_in = idx_field;
            acc_in = acc_field;
            if (field_done) begin
               phase_in = wsp_pkg::PH_WAVE;
               acc_in   = '0;
            end
         end
         wsp_pkg::PH_CID: begin
            idx_in = idx_field;
            acc_in = acc_field;
            if (field_done) begin
               acc_in = '0;
               if (acc_field == wsp_pkg::TAG_FMT) begin
                  phase_in = wsp_pkg::PH_FMTSIZE;
               end else if (acc_field == wsp_pkg::TAG_DATA) begin
                  phase_in = wsp_pkg::PH_DATASIZE;
               end else begin
                  phase_in = wsp_pkg::PH_OTHERSIZE;
               end
            end
         end
         wsp_pkg::PH_FMTSIZE: begin
            idx_in = idx_field;
            acc_in = acc_field;
            if (field_done) begin
               len_in = acc_field;
               if (acc_field < wsp_pkg::FMT_MIN_LEN) begin
                  err = wsp_pkg::ERR_FMT_SHORT;
               end else begin
                  phase_in = wsp_pkg::PH_FMTBODY;
                  acc_in   = '0;
               end
            end
         end
         wsp_pkg::PH_OTHERSIZE: begin
            idx_in = idx_field;
            acc_in = acc_field;
            if (field_done) begin
               len_in   = acc_field;
               acc_in   = '0;
               phase_in = (acc_field != '0) ? wsp_pkg::PH_SKIP : wsp_pkg::PH_CID;
            end
         end
         wsp_pkg::PH_FMTBODY: begin
            // Byte lanes of the first 16 fmt bytes; the rest are ignored.
            case (idx_c)
               4'd0:    fmtc_in = {8'b0, b};
               4'd1:    fmtc_in = {b, fmtc_c[7:0]};
               4'd2:    chan_in = {8'b0, b};
               4'd3:    chan_in = {b, chan_c[7:0]};
               4'd4:    rate_in = {24'b0, b};
               4'd5:    rate_in = {rate_c[31:16], b, rate_c[7:0]};
               4'd6:    rate_in = {rate_c[31:24], b, rate_c[15:0]};
               4'd7:    rate_in = {b, rate_c[23:0]};
               4'd14:   bits_in = {8'b0, b};
               4'd15:   bits_in = {b, bits_c[7:0]};
               default: ;
            endcase
            idx_in = idx_c + 4'd1;
            if (idx_c == wsp_pkg::FMT_BODY_LAST) begin
               seen_in  = 1'b1;
               len_in   = len_c - wsp_pkg::FMT_MIN_LEN;
               phase_in = (len_c != wsp_pkg::FMT_MIN_LEN) ?
                          wsp_pkg::PH_SKIP : wsp_pkg::PH_CID;
               idx_in   = '0;
               acc_in   = '0;
            end
         end
         wsp_pkg::PH_SKIP: begin
            len_in = len_dec;
            if (len_dec == '0) begin
               phase_in = wsp_pkg::PH_CID;
               idx_in   = '0;
               acc_in   = '0;
            end
         end
         wsp_pkg::PH_DATASIZE: begin
            idx_in = idx_field;
            acc_in = acc_field;
            if (field_done) begin
               len_in = acc_field;
               if (!seen_c) begin
                  err = wsp_pkg::ERR_MISSING;
               end else if (fmtc_c != wsp_pkg::FMT_PCM) begin
                  err = wsp_pkg::ERR_NOT_PCM;
               end else if (bits_c != wsp_pkg::BITS_16) begin
                  err = wsp_pkg::ERR_NOT_16BIT;
               end else if (chan_c != wsp_pkg::CH_MONO &&
                            chan_c != wsp_pkg::CH_STEREO) begin
                  err = wsp_pkg::ERR_CHANNELS;
               end else begin
                  res_valid = 1'b1;
                  res_kind  = wsp_pkg::KIND_ACCEPT;
                  res_rate  = rate_c;
                  res_chan  = chan_c;
                  phase_in  = wsp_pkg::PH_DATA;
                  acc_in    = '0;
                  pos_in    = '0;
               end
            end
         end
         wsp_pkg::PH_DATA: begin
            // Even positions hold the low byte, odd ones complete a sample.
            if (pos_c inside {2'd0, 2'd2}) begin
               lowb_in = b;
               pos_in  = pos_c + 2'd1;
            end else if (chan_c == wsp_pkg::CH_MONO) begin
               res_valid = 1'b1;
               res_left  = scaled;
               res_right = scaled;
               pos_in    = '0;
            end else if (pos_c == 2'd1) begin
               lefth_in = scaled;
               pos_in   = 2'd2;
            end else begin
               res_valid = 1'b1;
               res_left  = lefth_c;
               res_right = scaled;
               pos_in    = '0;
            end
         end
         default: ;
      endcase

      // A rejection replaces any other result and parks the parser.
      if (err != wsp_pkg::ERR_NONE) begin
         res_valid = 1'b1;
         res_kind  = wsp_pkg::KIND_REJECT;
         res_err   = err;
         res_rate  = '0;
         res_chan  = '0;
         res_left  = '0;
         res_right = '0;
         phase_in  = wsp_pkg::PH_IDLE;
      end

      // End of file inside an unfinished header is a missing chunk; any end of file parks the parser.
      if (beat.end_of_file) begin
         if (!res_valid && phase_in != wsp_pkg::PH_DATA &&
             phase_in != wsp_pkg::PH_IDLE) begin
            res_valid = 1'b1;
            res_kind  = wsp_pkg::KIND_REJECT;
            res_err   = wsp_pkg::ERR_MISSING;
         end
         phase_in = wsp_pkg::PH_IDLE;
      end
   end

   // Parse state registers advance on each taken beat.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= wsp_pkg::PH_RIFF;
         idx_ff   <= '0;
         acc_ff   <= '0;
         len_ff   <= '0;
         fmtc_ff  <= '0;
         chan_ff  <= '0;
         rate_ff  <= '0;
         bits_ff  <= '0;
         seen_ff  <= 1'b0;
         lowb_ff  <= '0;
         lefth_ff <= '0;
         pos_ff   <= '0;
      end else if (take) begin
         phase_ff <= phase_in;
         idx_ff   <= idx_in;
         acc_ff   <= acc_in;
         len_ff   <= len_in;
         fmtc_ff  <= fmtc_in;
         chan_ff  <= chan_in;
         rate_ff  <= rate_in;
         bits_ff  <= bits_in;
         seen_ff  <= seen_in;
         lowb_ff  <= lowb_in;
         lefth_ff <= lefth_in;
         pos_ff   <= pos_in;
      end
   end

   // Output register: loaded by a taken beat with a result, emptied when read and not refilled.
   always_comb begin
      if (take) begin
         rsp_valid_in = res_valid;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take && res_valid) begin
         rsp_kind_ff <= res_kind;
         rsp_data_ff <= {{(wsp_pkg::RSP_DATA_W - wsp_pkg::RSP_USED_W){1'b0}},
                         res_right, res_left, res_chan, res_rate, res_err};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_kind_ff;

   // An accepted header moves the parser to the sample phase unless the same byte ends the file.
   a_accept_enters_data: assert property (@(posedge clock) disable iff (reset)
      take && res_valid && res_kind == wsp_pkg::KIND_ACCEPT && !beat.end_of_file
      |=> phase_ff == wsp_pkg::PH_DATA)
      else $error("accepted header did not enter the sample phase");

   // A rejection carries an error code.
   a_reject_has_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_kind_ff == wsp_pkg::KIND_REJECT
      |-> rsp_data_ff[wsp_pkg::RSP_RATE_LSB-1:wsp_pkg::RSP_ERR_LSB] != wsp_pkg::ERR_NONE)
      else $error("rejection without an error code");

   // A mono stream never waits for a right sample.
   a_mono_no_pair: assert property (@(posedge clock) disable iff (reset)
      phase_ff == wsp_pkg::PH_DATA && chan_ff == wsp_pkg::CH_MONO |-> pos_ff != 2'd2)
      else $error("mono stream holding a left sample");

   // Mono frames carry the same sample on both channels.
   a_mono_equal: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_kind_ff == wsp_pkg::KIND_AUDIO && chan_ff == wsp_pkg::CH_MONO
      |-> rsp_data_ff[wsp_pkg::RSP_RIGHT_LSB-1:wsp_pkg::RSP_LEFT_LSB] ==
          rsp_data_ff[wsp_pkg::RSP_USED_W-1:wsp_pkg::RSP_RIGHT_LSB])
      else $error("mono frame with unequal channels");

endmodule
